// ===== rtl/thl_pkg.sv =====
// Package for the timestamped history lookup: store geometry, function codes,
// beat structs. No dependencies.
package thl_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = AW + 1;

  localparam logic [1:0] FUNC_PUSH_ATT  = 2'd0;
  localparam logic [1:0] FUNC_PUSH_POSE = 2'd1;
  localparam logic [1:0] FUNC_PRUNE     = 2'd2;
  localparam logic [1:0] FUNC_LOOKUP    = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic [47:0]        stamp;
    logic signed [31:0] roll_in;
    logic signed [31:0] pitch_in;
    logic signed [31:0] yaw_in;
    logic signed [31:0] pos_x_in;
    logic signed [31:0] pos_y_in;
  } thl_in_t;

  typedef struct packed {
    logic               att_hit;
    logic               pose_hit;
    logic               both_hit;
    logic signed [31:0] roll_out;
    logic signed [31:0] pitch_out;
    logic signed [31:0] yaw_out;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic               dropped;
    logic [8:0]         att_removed;
    logic [8:0]         pose_removed;
  } thl_out_t;

  // command from the sequencer to one store
  typedef struct packed {
    logic          push;
    logic          prune_start;
    logic          look_start;
    logic [47:0]   stamp;
    logic [31:0]   span;
    logic [95:0]   data;
  } thl_cmd_t;

  // status from one store back to the sequencer
  typedef struct packed {
    logic        done;
    logic        hit;
    logic        dropped;
    logic [8:0]  removed;
    logic [95:0] data;
  } thl_sts_t;

endpackage

// ===== rtl/thl_store.sv =====
// One time-ordered ring store: memory, head/count, prune walk, lookup walk.
// Depends on thl_pkg.
module thl_store (
  input  logic             clk,
  input  logic             rst_n,
  input  thl_pkg::thl_cmd_t cmd,
  output thl_pkg::thl_sts_t sts
);
  import thl_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRUNE = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [143:0] mem [STORE_DEPTH];
  logic [143:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pos_r, pos_nxt;      // entries still to visit in a lookup
  logic          rd_vld_r, rd_vld_nxt;
  logic          have_cur_r, have_cur_nxt;
  logic [47:0]   cur_stamp_r, cur_stamp_nxt;
  logic [95:0]   cur_data_r, cur_data_nxt;
  logic [47:0]   key_r;
  logic [31:0]   span_r;
  logic [8:0]    removed_r, removed_nxt;
  thl_sts_t      sts_nxt;
  thl_sts_t      sts_r;

  assign sts = sts_r;

  logic [AW-1:0] tail_slot;
  assign tail_slot = head_r + count_r[AW-1:0];

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    rd_vld_nxt   = 1'b0;
    have_cur_nxt = have_cur_r;
    cur_stamp_nxt = cur_stamp_r;
    cur_data_nxt = cur_data_r;
    removed_nxt  = removed_r;
    rd_addr      = head_r;
    wr_en        = 1'b0;
    wr_addr      = tail_slot;
    sts_nxt      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.push) begin
          wr_en = 1'b1;
          sts_nxt.done = 1'b1;
          if (count_r == CW'(STORE_DEPTH)) begin
            wr_addr  = head_r;
            head_nxt = head_r + 1'b1;
            sts_nxt.dropped = 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end else if (cmd.prune_start) begin
          removed_nxt = '0;
          if (count_r == '0) begin
            sts_nxt.done = 1'b1;
          end else begin
            rd_addr    = head_r;
            rd_vld_nxt = 1'b1;
            state_nxt  = S_PRUNE;
          end
        end else if (cmd.look_start) begin
          have_cur_nxt = 1'b0;
          if (count_r < CW'(2)) begin
            sts_nxt.done = 1'b1;
          end else begin
            rd_addr    = head_r + count_r[AW-1:0] - 1'b1;
            rd_vld_nxt = 1'b1;
            pos_nxt    = count_r - 1'b1;
            state_nxt  = S_LOOK;
          end
        end
      end
      S_PRUNE: begin
        // one entry per cycle: decide on the word read last cycle, read the next
        if (rd_vld_r) begin
          if ({1'b0, rd_q[143:96]} + {17'd0, span_r} < {1'b0, key_r}) begin
            head_nxt  = head_r + 1'b1;
            count_nxt = count_r - 1'b1;
            if (removed_r != 9'd511) removed_nxt = removed_r + 1'b1;
            if (count_r == CW'(1)) begin
              state_nxt = S_IDLE;
              sts_nxt.done = 1'b1;
              sts_nxt.removed = (removed_r != 9'd511) ? removed_r + 1'b1 : removed_r;
            end else begin
              rd_addr    = head_r + 1'b1;
              rd_vld_nxt = 1'b1;
            end
          end else begin
            state_nxt = S_IDLE;
            sts_nxt.done = 1'b1;
            sts_nxt.removed = removed_r;
          end
        end
      end
      S_LOOK: begin
        if (rd_vld_r) begin
          // rd_q is the entry at logical position pos_r
          if (have_cur_r && rd_q[143:96] < key_r && cur_stamp_r > key_r) begin
            state_nxt = S_IDLE;
            sts_nxt.done = 1'b1;
            sts_nxt.hit  = 1'b1;
            sts_nxt.data = cur_data_r;
          end else if (pos_r == '0) begin
            state_nxt = S_IDLE;
            sts_nxt.done = 1'b1;
          end else begin
            have_cur_nxt  = 1'b1;
            cur_stamp_nxt = rd_q[143:96];
            cur_data_nxt  = rd_q[95:0];
            pos_nxt    = pos_r - 1'b1;
            rd_addr    = head_r + pos_r[AW-1:0] - 1'b1;
            rd_vld_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {cmd.stamp, cmd.data};
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      count_r   <= '0;
      rd_vld_r  <= 1'b0;
      sts_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      rd_vld_r  <= rd_vld_nxt;
      sts_r     <= sts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    have_cur_r  <= have_cur_nxt;
    cur_stamp_r <= cur_stamp_nxt;
    cur_data_r  <= cur_data_nxt;
    removed_r   <= removed_nxt;
    if (state_r == S_IDLE) begin
      key_r  <= cmd.stamp;
      span_r <= cmd.span;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STORE_DEPTH)) else $error("count beyond depth");
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cmd.push && count_r == CW'(STORE_DEPTH)) |=>
      count_r == CW'(STORE_DEPTH) && sts_r.dropped) else $error("full push");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sts_r.done |-> state_r == S_IDLE) else $error("done while busy");

endmodule

// ===== rtl/timestamped_history_lookup.sv =====
// Top level: handshake, span register, sequencing of the two ring stores.
// Depends on thl_pkg and thl_store.
//
// Keeps 256-entry attitude and pose histories in on-chip RAM. A push returns its
// result beat through the store's status register and the output register, and
// the next beat is taken once that result is registered. A prune or lookup walks
// the RAM of each store (both in parallel), one entry per cycle since each
// decision uses the word read on the cycle before; the input is free again once
// the result is registered, and a stalled output holds that back. One item is
// processed at a time; a finished result sits in an output register while the
// next item is taken.
module timestamped_history_lookup (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  thl_pkg::thl_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output thl_pkg::thl_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);
  import thl_pkg::*;

  logic [31:0] span_r;
  logic        busy_r;
  logic [1:0]  func_r;
  logic        att_done_r, pose_done_r;
  thl_sts_t    att_keep_r, pose_keep_r;
  thl_cmd_t    att_cmd, pose_cmd;
  thl_sts_t    att_sts, pose_sts;
  thl_out_t    res;
  logic        in_acc, out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy_r;
  assign in_acc    = in_valid && !busy_r;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    att_cmd = '0;
    att_cmd.stamp = in_data.stamp;
    att_cmd.span  = span_r;
    att_cmd.data  = {in_data.roll_in, in_data.pitch_in, in_data.yaw_in};
    att_cmd.push        = in_acc && in_data.func == FUNC_PUSH_ATT;
    att_cmd.prune_start = in_acc && in_data.func == FUNC_PRUNE;
    att_cmd.look_start  = in_acc && in_data.func == FUNC_LOOKUP;
    pose_cmd = '0;
    pose_cmd.stamp = in_data.stamp;
    pose_cmd.span  = span_r;
    pose_cmd.data  = {32'd0, in_data.pos_x_in, in_data.pos_y_in};
    pose_cmd.push        = in_acc && in_data.func == FUNC_PUSH_POSE;
    pose_cmd.prune_start = att_cmd.prune_start;
    pose_cmd.look_start  = att_cmd.look_start;
  end

  thl_store u_att  (.clk(clk), .rst_n(rst_n), .cmd(att_cmd),  .sts(att_sts));
  thl_store u_pose (.clk(clk), .rst_n(rst_n), .cmd(pose_cmd), .sts(pose_sts));

  logic a_dn, p_dn, all_dn;
  thl_sts_t a_s, p_s;
  assign a_dn = att_done_r || att_sts.done;
  assign p_dn = pose_done_r || pose_sts.done;
  assign a_s  = att_done_r ? att_keep_r : att_sts;
  assign p_s  = pose_done_r ? pose_keep_r : pose_sts;
  // a push only involves one store
  assign all_dn = (func_r == FUNC_PUSH_ATT)  ? a_dn :
                  (func_r == FUNC_PUSH_POSE) ? p_dn : (a_dn && p_dn);

  always_comb begin
    res = '0;
    case (func_r)
      FUNC_PUSH_ATT:  res.dropped = a_s.dropped;
      FUNC_PUSH_POSE: res.dropped = p_s.dropped;
      FUNC_PRUNE: begin
        res.att_removed  = a_s.removed;
        res.pose_removed = p_s.removed;
      end
      default: begin
        res.att_hit   = a_s.hit;
        res.pose_hit  = p_s.hit;
        res.both_hit  = a_s.hit && p_s.hit;
        res.roll_out  = a_s.data[95:64];
        res.pitch_out = a_s.data[63:32];
        res.yaw_out   = a_s.data[31:0];
        res.pos_x_out = p_s.data[63:32];
        res.pos_y_out = p_s.data[31:0];
      end
    endcase
  end

  logic fin;
  assign fin = busy_r && all_dn && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r      <= 32'd2000000;
      busy_r      <= 1'b0;
      out_valid   <= 1'b0;
      att_done_r  <= 1'b0;
      pose_done_r <= 1'b0;
    end else begin
      if (cfg_valid) span_r <= cfg_data;
      if (fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_acc) begin
        busy_r      <= 1'b1;
        att_done_r  <= 1'b0;
        pose_done_r <= 1'b0;
      end else if (fin) begin
        busy_r    <= 1'b0;
      end else if (busy_r) begin
        if (att_sts.done)  att_done_r  <= 1'b1;
        if (pose_sts.done) pose_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) func_r <= in_data.func;
    if (att_sts.done)  att_keep_r  <= att_sts;
    if (pose_sts.done) pose_keep_r <= pose_sts;
    if (fin) out_data <= res;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r) else $error("accept did not start work");
  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid && !busy_r) else $error("finish lost");
  a_both_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.both_hit == (out_data.att_hit && out_data.pose_hit))
    else $error("both_hit mismatch");

endmodule

// ===== verif/thl_checker.sv =====
// Checker for timestamped_history_lookup: watches the input, result and span
// write channels, predicts each result beat and compares it. Depends on thl_pkg.
`timescale 1ns / 100ps

module thl_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  thl_pkg::thl_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  thl_pkg::thl_out_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  output int                errors,
  output int                pending
);
  import thl_pkg::*;

  logic [31:0] span;

  logic [47:0] att_stamp [STORE_DEPTH];
  logic [31:0] att_roll [STORE_DEPTH];
  logic [31:0] att_pitch [STORE_DEPTH];
  logic [31:0] att_yaw [STORE_DEPTH];
  logic [AW-1:0] att_head;
  logic [CW-1:0] att_cnt;

  logic [47:0] pose_stamp [STORE_DEPTH];
  logic [31:0] pose_x [STORE_DEPTH];
  logic [31:0] pose_y [STORE_DEPTH];
  logic [AW-1:0] pose_head;
  logic [CW-1:0] pose_cnt;

  thl_out_t expected_q[$];

  // pick the next slot of a store; a full store overwrites its oldest entry
  function automatic logic [AW-1:0] append_slot(ref logic [AW-1:0] head,
                                                 ref logic [CW-1:0] cnt,
                                                 output logic drop);
    logic [AW-1:0] s;
    if (cnt == CW'(STORE_DEPTH)) begin
      s = head;
      head = head + 1'b1;
      drop = 1'b1;
    end else begin
      s = head + AW'(cnt);
      cnt = cnt + 1'b1;
      drop = 1'b0;
    end
    return s;
  endfunction

  function automatic logic [8:0] prune_att(logic [47:0] ref_t);
    logic [8:0] n;
    n = '0;
    while (att_cnt > 0 && ({1'b0, att_stamp[att_head]} + {17'd0, span}) < {1'b0, ref_t}) begin
      att_head = att_head + 1'b1;
      att_cnt = att_cnt - 1'b1;
      n++;
    end
    return n;
  endfunction

  function automatic logic [8:0] prune_pose(logic [47:0] ref_t);
    logic [8:0] n;
    n = '0;
    while (pose_cnt > 0 &&
           ({1'b0, pose_stamp[pose_head]} + {17'd0, span}) < {1'b0, ref_t}) begin
      pose_head = pose_head + 1'b1;
      pose_cnt = pose_cnt - 1'b1;
      n++;
    end
    return n;
  endfunction

  // scan newest to oldest for an entry after the search time whose
  // predecessor is before it
  function automatic logic find_att(logic [47:0] t, output logic [AW-1:0] slot);
    logic [AW-1:0] cur, prv;
    for (int pos = int'(att_cnt); pos >= 2; pos--) begin
      cur = att_head + AW'(pos - 1);
      prv = att_head + AW'(pos - 2);
      if (att_stamp[prv] < t && att_stamp[cur] > t) begin
        slot = cur;
        return 1'b1;
      end
    end
    slot = '0;
    return 1'b0;
  endfunction

  function automatic logic find_pose(logic [47:0] t, output logic [AW-1:0] slot);
    logic [AW-1:0] cur, prv;
    for (int pos = int'(pose_cnt); pos >= 2; pos--) begin
      cur = pose_head + AW'(pos - 1);
      prv = pose_head + AW'(pos - 2);
      if (pose_stamp[prv] < t && pose_stamp[cur] > t) begin
        slot = cur;
        return 1'b1;
      end
    end
    slot = '0;
    return 1'b0;
  endfunction

  function automatic thl_out_t history_result(thl_in_t it);
    thl_out_t r;
    logic [AW-1:0] s;
    logic drop;
    r = '0;
    case (it.func)
      FUNC_PUSH_ATT: begin
        s = append_slot(att_head, att_cnt, drop);
        att_stamp[s] = it.stamp;
        att_roll[s] = it.roll_in;
        att_pitch[s] = it.pitch_in;
        att_yaw[s] = it.yaw_in;
        r.dropped = drop;
      end
      FUNC_PUSH_POSE: begin
        s = append_slot(pose_head, pose_cnt, drop);
        pose_stamp[s] = it.stamp;
        pose_x[s] = it.pos_x_in;
        pose_y[s] = it.pos_y_in;
        r.dropped = drop;
      end
      FUNC_PRUNE: begin
        r.att_removed = prune_att(it.stamp);
        r.pose_removed = prune_pose(it.stamp);
      end
      default: begin
        r.att_hit = find_att(it.stamp, s);
        if (r.att_hit) begin
          r.roll_out = att_roll[s];
          r.pitch_out = att_pitch[s];
          r.yaw_out = att_yaw[s];
        end
        r.pose_hit = find_pose(it.stamp, s);
        if (r.pose_hit) begin
          r.pos_x_out = pose_x[s];
          r.pos_y_out = pose_y[s];
        end
        r.both_hit = r.att_hit & r.pose_hit;
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    thl_out_t e;
    if (!rst_n) begin
      errors = 0;
      span = 32'd2000000;
      att_head = '0;
      att_cnt = '0;
      pose_head = '0;
      pose_cnt = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) span = cfg_data;
      if (in_valid && !in_stall)
        expected_q.insert(expected_q.size(), history_result(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat %h", $realtime, out_data);
        end else begin
          e = expected_q.pop_front();
          check_field("att_hit", e.att_hit, out_data.att_hit);
          check_field("pose_hit", e.pose_hit, out_data.pose_hit);
          check_field("both_hit", e.both_hit, out_data.both_hit);
          check_field("roll_out", e.roll_out, out_data.roll_out);
          check_field("pitch_out", e.pitch_out, out_data.pitch_out);
          check_field("yaw_out", e.yaw_out, out_data.yaw_out);
          check_field("pos_x_out", e.pos_x_out, out_data.pos_x_out);
          check_field("pos_y_out", e.pos_y_out, out_data.pos_y_out);
          check_field("dropped", e.dropped, out_data.dropped);
          check_field("att_removed", e.att_removed, out_data.att_removed);
          check_field("pose_removed", e.pose_removed, out_data.pose_removed);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/tb_timestamped_history_lookup.sv =====
// Testbench top for timestamped_history_lookup: clock, reset, stimulus,
// span writes and verdict. Depends on thl_pkg, the RTL and thl_checker.
`timescale 1ns / 100ps

module tb_timestamped_history_lookup;
  import thl_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam logic [47:0] STAMP_MAX = 48'hFFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  thl_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  thl_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          prune_pct;
  int          beats_sent;
  int          quiet_cycles;
  logic [47:0] now_us;
  logic [47:0] last_stamp;

  timestamped_history_lookup u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  thl_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stall, plus one long hold-off while the sender keeps going
  initial begin
    out_stall = 1'b0;
    wait (beats_sent >= 150);
    @(negedge clk);
    out_stall = 1'b1;
    repeat (700) @(negedge clk);
    forever begin
      out_stall = ($urandom_range(0, 99) < recv_idle_pct);
      @(negedge clk);
    end
  end

  task automatic send_beat(thl_in_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_span(logic [31:0] v);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic thl_in_t mk_item(logic [1:0] f, logic [47:0] t);
    thl_in_t it;
    it.func = f;
    it.stamp = t;
    it.roll_in = $urandom;
    it.pitch_in = $urandom;
    it.yaw_in = $urandom;
    it.pos_x_in = $urandom;
    it.pos_y_in = $urandom;
    return it;
  endfunction

  function automatic logic [47:0] back_off(logic [47:0] t, int unsigned d);
    return (t > 48'(d)) ? t - 48'(d) : 48'd0;
  endfunction

  // mostly time-ordered traffic around a moving clock, some random noise
  task automatic run_traffic(int n);
    thl_in_t it;
    int r;
    logic [47:0] t;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < prune_pct) begin
        t = back_off(now_us, $urandom_range(0, 4000000));
        it = mk_item(FUNC_PRUNE, t);
      end else if (r < prune_pct + 25) begin
        case ($urandom_range(0, 3))
          0: t = last_stamp;
          1: t = back_off(now_us, $urandom_range(0, 300000));
          default: t = back_off(now_us, $urandom_range(0, 3000000));
        endcase
        it = mk_item(FUNC_LOOKUP, t);
      end else begin
        now_us = now_us + 48'($urandom_range(1, 60000));
        it = mk_item($urandom_range(0, 1) ? FUNC_PUSH_ATT : FUNC_PUSH_POSE, now_us);
        last_stamp = now_us;
      end
      // noise: any function with an arbitrary stamp
      if ($urandom_range(0, 99) < 6) it.stamp = 48'({$urandom, $urandom});
      if ($urandom_range(0, 199) == 0) it.stamp = STAMP_MAX;
      it.func = ($urandom_range(0, 99) < 4) ? 2'($urandom) : it.func;
      send_beat(it);
      // let the block drain once in a while
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  initial begin
    thl_in_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    beats_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    prune_pct = 10;
    now_us = 48'($urandom);
    last_stamp = now_us;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty lookup, extreme payloads, equal stamps, wrap stamps, prunes
    send_beat(mk_item(FUNC_LOOKUP, 48'd0));
    it = mk_item(FUNC_PUSH_ATT, 48'd0);
    it.roll_in = 32'h8000_0000; it.pitch_in = 32'h7FFF_FFFF; it.yaw_in = 32'hFFFF_FFFF;
    send_beat(it);
    send_beat(mk_item(FUNC_LOOKUP, 48'd500));
    it = mk_item(FUNC_PUSH_ATT, 48'd1000);
    it.roll_in = 32'h7FFF_FFFF; it.pitch_in = 32'h8000_0000; it.yaw_in = 32'd0;
    send_beat(it);
    it = mk_item(FUNC_PUSH_POSE, 48'd0);
    it.pos_x_in = 32'h8000_0000; it.pos_y_in = 32'h7FFF_FFFF;
    send_beat(it);
    send_beat(mk_item(FUNC_LOOKUP, 48'd500));
    it = mk_item(FUNC_PUSH_POSE, 48'd1000);
    it.pos_x_in = 32'h7FFF_FFFF; it.pos_y_in = 32'h8000_0000;
    send_beat(it);
    send_beat(mk_item(FUNC_LOOKUP, 48'd500));
    send_beat(mk_item(FUNC_LOOKUP, 48'd0));
    send_beat(mk_item(FUNC_LOOKUP, 48'd1000));
    send_beat(mk_item(FUNC_PUSH_ATT, STAMP_MAX));
    send_beat(mk_item(FUNC_LOOKUP, STAMP_MAX - 1));
    send_beat(mk_item(FUNC_LOOKUP, STAMP_MAX));
    send_beat(mk_item(FUNC_PUSH_ATT, 48'd10));
    send_beat(mk_item(FUNC_LOOKUP, 48'd5));
    send_beat(mk_item(FUNC_PRUNE, 48'd0));
    send_beat(mk_item(FUNC_PRUNE, 48'd2000000));
    send_beat(mk_item(FUNC_PRUNE, 48'd2000001));
    send_beat(mk_item(FUNC_PRUNE, STAMP_MAX));
    send_beat(mk_item(FUNC_LOOKUP, 48'd5));

    // huge span, rare prunes: stores grow; sender pauses to drain
    write_span(32'hFFFF_FFFF);
    send_idle_pct = 13;
    recv_idle_pct = 80;
    prune_pct = 2;
    run_traffic(250);
    wait_drained();
    run_traffic(250);

    write_span(32'd0);
    send_idle_pct = 80;
    recv_idle_pct = 13;
    prune_pct = 10;
    run_traffic(500);

    write_span($urandom_range(1, 3000000));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_traffic(280);
    write_span(32'd2000000);
    run_traffic(250);

    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/thl_pkg.sv
rtl/thl_store.sv
rtl/timestamped_history_lookup.sv
verif/thl_checker.sv
verif/tb_timestamped_history_lookup.sv
